// ===== src/pbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet burst coalescer package
// Word types for the input and result channels and the burst direction codes.
// ----------------------------------------------------------------------------
package pbc_pkg;

  // Direction of the packet that opened the current burst.
  typedef enum logic [1:0] {
    DIR_ZERO = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  // One packet record.
  typedef struct packed {
    logic signed [16:0] pkt_size;
    logic [30:0]        pkt_time;
    logic [31:0]        stop_prob;
    logic               last_pkt;
  } in_word_t;

  // One closed burst.
  typedef struct packed {
    logic signed [31:0] burst_size;
    logic signed [31:0] burst_time;
    logic [31:0]        burst_prob;
    logic [15:0]        burst_count;
    logic               last_burst;
  } out_word_t;

  localparam logic [30:0] WINDOW_RESET = 31'd200000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

endpackage

// ===== src/packet_burst_coalescer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet burst coalescer unit
// Merges a trace of signed packet records into bursts of one direction that
// fit within a time window, and emits one word per closed burst.
// ----------------------------------------------------------------------------
// A packet word is taken in every cycle in which the block is not stalled; its
// burst decision and the accumulator update happen in the same cycle, and the
// zero, one or two burst words it closes go into a four-entry result queue.
// The result side drains one word a cycle while out_stall is low, so the input stalls
// only while the queue has fewer than two free entries: a sustained rate of one packet
// per cycle, limited by the single output port when most packets close a burst.
// The merge window register may be written only while the block is idle.
module packet_burst_coalescer_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [30:0]      cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  pbc_pkg::in_word_t  in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output pbc_pkg::out_word_t out_word
);
  import pbc_pkg::*;

  // Configuration and trace state.
  logic [30:0]        merge_window;
  logic [30:0]        base_time;
  logic               trace_started;
  dir_t               open_dir;
  logic signed [31:0] open_start_time;
  logic signed [31:0] acc_size;
  logic signed [31:0] acc_last_time;
  logic [31:0]        acc_prob;
  logic [15:0]        acc_count;

  // Result queue.
  out_word_t  fifo_mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  // Datapath signals.
  logic               accept;
  logic               pop;
  logic signed [31:0] rel;
  logic signed [32:0] diff;
  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;
  logic               size_neg;
  logic               size_pos;
  logic               open_now;
  logic               sign_break;
  logic               time_break;
  logic               brk;
  dir_t               dir_next;
  logic signed [31:0] open_start_time_next;
  logic signed [31:0] acc_size_next;
  logic [15:0]        acc_count_next;
  out_word_t          close_word;
  out_word_t          flush_word;

  assign accept    = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count > 3'd2);
  assign out_word  = fifo_mem[rd_ptr];

  // Relative time of this packet and its distance from the opener.
  always_comb begin
    if (trace_started) begin
      rel = $signed({1'b0, in_word.pkt_time}) - $signed({1'b0, base_time});
    end else begin
      rel = '0;
    end
    diff = {rel[31], rel} - {open_start_time[31], open_start_time};
  end

  // Burst decision.
  always_comb begin
    size_neg   = in_word.pkt_size[16];
    size_pos   = !size_neg && (in_word.pkt_size != '0);
    open_now   = !trace_started || (acc_count == '0);
    sign_break = (size_neg && open_dir == DIR_POS) || (size_pos && open_dir == DIR_NEG);
    time_break = diff[32] || (diff >= $signed({2'b00, merge_window}));
    brk        = !open_now && (sign_break || time_break);
  end

  // Saturating size sum.
  always_comb begin
    sum = {acc_size[31], acc_size} + 33'(in_word.pkt_size);
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Next accumulator contents: open a new burst or merge into the open one.
  always_comb begin
    if (open_now || brk) begin
      if (size_pos) begin
        dir_next = DIR_POS;
      end else if (size_neg) begin
        dir_next = DIR_NEG;
      end else begin
        dir_next = DIR_ZERO;
      end
      open_start_time_next = rel;
      acc_size_next        = 32'(in_word.pkt_size);
      acc_count_next       = 16'd1;
    end else begin
      dir_next             = open_dir;
      open_start_time_next = open_start_time;
      acc_size_next        = sum_sat;
      acc_count_next       = (acc_count == COUNT_MAX) ? acc_count : acc_count + 16'd1;
    end
  end

  // Words for the closed burst and for the flushed burst.
  always_comb begin
    close_word.burst_size  = acc_size;
    close_word.burst_time  = acc_last_time;
    close_word.burst_prob  = acc_prob;
    close_word.burst_count = acc_count;
    close_word.last_burst  = 1'b0;
    flush_word.burst_size  = acc_size_next;
    flush_word.burst_time  = rel;
    flush_word.burst_prob  = in_word.stop_prob;
    flush_word.burst_count = acc_count_next;
    flush_word.last_burst  = 1'b1;
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      merge_window  <= WINDOW_RESET;
      trace_started <= 1'b0;
      open_dir      <= DIR_ZERO;
      acc_count     <= '0;
    end else begin
      if (cfg_wr_en) begin
        merge_window <= cfg_wr_data;
      end
      if (accept) begin
        trace_started <= !in_word.last_pkt;
        open_dir      <= dir_next;
        acc_count     <= in_word.last_pkt ? 16'd0 : acc_count_next;
      end
    end
  end

  // Accumulator payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!trace_started) begin
        base_time <= in_word.pkt_time;
      end
      open_start_time <= open_start_time_next;
      acc_size        <= acc_size_next;
      acc_last_time   <= rel;
      acc_prob        <= in_word.stop_prob;
    end
  end

  // Result queue pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 2'(brk) + 2'(in_word.last_pkt);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(accept && brk) + 3'(accept && in_word.last_pkt) - 3'(pop);
    end
  end

  // Result queue storage: the closed burst goes first, then the flushed one.
  always_ff @(posedge clk) begin
    if (accept && brk) begin
      fifo_mem[wr_ptr] <= close_word;
    end
    if (accept && in_word.last_pkt) begin
      fifo_mem[wr_ptr + 2'(brk)] <= flush_word;
    end
  end

`ifndef ASSERT_OFF
  // The queue never holds more than its four entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overflow");

  // While the input is stalled nothing is pushed into the queue.
  a_no_push_stalled: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> count <= $past(count))
    else $error("queue grew while input stalled");

  // The last packet of a trace ends it and leaves no burst open.
  a_last_ends_trace: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.last_pkt |=> !trace_started && acc_count == '0)
    else $error("trace not closed after last packet");

  // Any other packet leaves an open burst in a running trace.
  a_burst_open: assert property (@(posedge clk) disable iff (rst)
    accept && !in_word.last_pkt |=> trace_started && acc_count != '0)
    else $error("no open burst after packet");
`endif

endmodule
